FILE: rtl/core/hset_pkg.sv
// ============================================================================
// Hitting-set search engine package
// Shared sizes, operation codes, status codes and a mask helper for the engine.
// ============================================================================
package hset_pkg;

    // Problem sizes.
    localparam int VERTEX_COUNT = 64;
    localparam int EDGE_COUNT   = 64;
    localparam int STACK_DEPTH  = 64;

    // Derived widths.
    localparam int VIDX_W  = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
    localparam int VCNT_W  = $clog2(VERTEX_COUNT + 1);
    localparam int SIDX_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int LEVEL_W = $clog2(STACK_DEPTH + 1);
    localparam int EIU_W   = 7;
    localparam int KIND_W  = 3;
    localparam int STAT_W  = 2;

    // Operation codes of an input item.
    typedef enum logic [KIND_W-1:0] {
        K_LOAD   = 3'd0,
        K_CLEAR  = 3'd1,
        K_CHECK  = 3'd2,
        K_ADD    = 3'd3,
        K_REMOVE = 3'd4
    } kind_t;

    // Status codes of a result item.
    localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
    localparam logic [STAT_W-1:0] ST_MEMBER     = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOT_MEMBER = 2'd2;
    localparam logic [STAT_W-1:0] ST_STACK      = 2'd3;

    // Uncovered mask after a clear: every edge index below n is set, saturating at the full mask.
    function automatic logic [EDGE_COUNT-1:0] start_mask(input logic [EIU_W-1:0] n);
        logic [EDGE_COUNT-1:0] m;
        m = '0;
        for (int i = 0; i < EDGE_COUNT; i++) begin
            m[i] = (EIU_W'(i) < n);
        end
        return m;
    endfunction

endpackage

FILE: rtl/core/hset_ram.sv
// ============================================================================
// Simple dual-port RAM
// One write port and one read port; read data registered.
// ============================================================================
module hset_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/core/hitting_set_crit_table_engine.sv
// ============================================================================
// Hitting-set critical-edge table engine
// Keeps incidence rows, per-vertex critical edges, uncovered mask, member set
// and an undo stack; serves load, clear, check, add and remove items.
// ============================================================================
// Load, clear and rejected items go from idle straight to the result.
// Check and add read the incidence row and then walk over all vertices
// through the critical-edge RAM port; remove walks without the row read.
// One item is in work at a time; a finished result waits in the output
// register while the next item is taken. Reset empties the search at once.
module hitting_set_crit_table_engine (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [hset_pkg::EIU_W-1:0]        cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [hset_pkg::KIND_W-1:0]       kind,
    input  logic [hset_pkg::VIDX_W-1:0]       vertex,
    input  logic [hset_pkg::EDGE_COUNT-1:0]   edge_bits,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              violates,
    output logic [hset_pkg::EDGE_COUNT-1:0]   uncovered_edges,
    output logic [hset_pkg::STAT_W-1:0]       status
);

    import hset_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_ROW, S_WALK, S_APPLY, S_DONE} state_t;

    localparam int STK_AW = SIDX_W + VIDX_W;

    state_t                  state_reg;
    kind_t                   kind_reg;
    logic [VIDX_W-1:0]       vtx_reg;
    logic [EDGE_COUNT-1:0]   row_reg;
    logic [STAT_W-1:0]       status_reg;
    logic                    viol_reg;
    logic [VERTEX_COUNT-1:0] member_reg;
    logic [EDGE_COUNT-1:0]   uncov_reg;
    logic [LEVEL_W-1:0]      level_reg;
    logic [EIU_W-1:0]        eiu_reg;
    logic [VERTEX_COUNT-1:0] crit_vld_reg;
    logic [VCNT_W-1:0]       rd_idx_reg;
    logic                    p_valid_reg;
    logic [VIDX_W-1:0]       p_idx_reg;
    logic                    p_cval_reg;
    logic                    out_valid_reg;
    logic                    out_viol_reg;
    logic [EDGE_COUNT-1:0]   out_uncov_reg;
    logic [STAT_W-1:0]       out_status_reg;

    logic                    accept;
    logic                    in_range;
    kind_t                   kind_in;
    logic [EDGE_COUNT-1:0]   row_rdata;
    logic [EDGE_COUNT-1:0]   crit_rdata;
    logic [EDGE_COUNT-1:0]   stk_rdata;
    logic                    crit_we;
    logic [VIDX_W-1:0]       crit_waddr;
    logic [EDGE_COUNT-1:0]   crit_wdata;
    logic                    stk_we;
    logic [EDGE_COUNT-1:0]   stk_wdata;
    logic [SIDX_W-1:0]       lvl_top;
    logic                    proc;
    logic                    keep;
    logic [EDGE_COUNT-1:0]   crit_cur;
    logic [EDGE_COUNT-1:0]   test_mask;

    assign kind_in   = kind_t'(kind);
    assign accept    = in_valid && (state_reg == S_IDLE);
    assign in_range  = ({1'b0, vertex} < VCNT_W'(VERTEX_COUNT));
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign violates  = out_viol_reg;
    assign uncovered_edges = out_uncov_reg;
    assign status    = out_status_reg;
    assign lvl_top   = SIDX_W'(level_reg - 1'b1);

    // Incidence rows, read at the vertex of the item being taken.
    hset_ram #(.WIDTH(EDGE_COUNT), .DEPTH(VERTEX_COUNT)) u_row_ram (
        .clk   (clk),
        .we    (accept && (kind_in == K_LOAD) && in_range),
        .waddr (vertex),
        .wdata (edge_bits),
        .raddr (vertex),
        .rdata (row_rdata)
    );

    // Critical edges per vertex; an entry without its valid bit reads as zero.
    hset_ram #(.WIDTH(EDGE_COUNT), .DEPTH(VERTEX_COUNT)) u_crit_ram (
        .clk   (clk),
        .we    (crit_we),
        .waddr (crit_waddr),
        .wdata (crit_wdata),
        .raddr (rd_idx_reg[VIDX_W-1:0]),
        .rdata (crit_rdata)
    );

    // Undo stack, one row of VERTEX_COUNT entries per level.
    hset_ram #(.WIDTH(EDGE_COUNT), .DEPTH(STACK_DEPTH * VERTEX_COUNT)) u_stk_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (STK_AW'({level_reg[SIDX_W-1:0], p_idx_reg})),
        .wdata (stk_wdata),
        .raddr (STK_AW'({lvl_top, rd_idx_reg[VIDX_W-1:0]})),
        .rdata (stk_rdata)
    );

    // Per-vertex work of the walk and the final write of an add.
    always_comb
    begin
        proc       = (state_reg == S_WALK) && p_valid_reg;
        crit_cur   = p_cval_reg ? crit_rdata : '0;
        keep       = member_reg[p_idx_reg] &&
                     !((kind_reg == K_REMOVE) && (p_idx_reg == vtx_reg));
        test_mask  = row_reg & ~uncov_reg;
        crit_we    = 1'b0;
        crit_waddr = p_idx_reg;
        crit_wdata = '0;
        stk_we     = 1'b0;
        stk_wdata  = '0;
        case (kind_reg)
            K_ADD:
            begin
                if (proc)
                begin
                    stk_we    = 1'b1;
                    stk_wdata = keep ? (crit_cur & row_reg) : '0;
                    if (keep)
                    begin
                        crit_we    = 1'b1;
                        crit_wdata = crit_cur & ~row_reg;
                    end
                end
                else if (state_reg == S_APPLY)
                begin
                    crit_we    = 1'b1;
                    crit_waddr = vtx_reg;
                    crit_wdata = row_reg & uncov_reg;
                end
            end
            K_REMOVE:
            begin
                if (proc && keep)
                begin
                    crit_we    = 1'b1;
                    crit_wdata = crit_cur | stk_rdata;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Sequencer, search state and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            kind_reg       <= K_LOAD;
            vtx_reg        <= '0;
            row_reg        <= '0;
            status_reg     <= ST_OK;
            viol_reg       <= 1'b0;
            member_reg     <= '0;
            uncov_reg      <= '1;
            level_reg      <= '0;
            eiu_reg        <= EIU_W'(64);
            crit_vld_reg   <= '0;
            rd_idx_reg     <= '0;
            p_valid_reg    <= 1'b0;
            p_idx_reg      <= '0;
            p_cval_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_viol_reg   <= 1'b0;
            out_uncov_reg  <= '0;
            out_status_reg <= ST_OK;
        end
        else
        begin
            if (cfg_we)
            begin
                eiu_reg <= cfg_data;
            end
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (crit_we)
            begin
                crit_vld_reg[crit_waddr] <= 1'b1;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        kind_reg    <= kind_in;
                        vtx_reg     <= vertex;
                        viol_reg    <= 1'b0;
                        status_reg  <= ST_OK;
                        rd_idx_reg  <= '0;
                        p_valid_reg <= 1'b0;
                        state_reg   <= S_DONE;
                        case (kind_in)
                            K_CLEAR:
                            begin
                                member_reg   <= '0;
                                uncov_reg    <= start_mask(eiu_reg);
                                level_reg    <= '0;
                                crit_vld_reg <= '0;
                            end
                            K_CHECK:
                            begin
                                if (!in_range)
                                    status_reg <= ST_NOT_MEMBER;
                                else if (member_reg[vertex])
                                    status_reg <= ST_MEMBER;
                                else
                                    state_reg <= S_ROW;
                            end
                            K_ADD:
                            begin
                                if (!in_range)
                                    status_reg <= ST_NOT_MEMBER;
                                else if (member_reg[vertex])
                                    status_reg <= ST_MEMBER;
                                else if (level_reg >= LEVEL_W'(STACK_DEPTH))
                                    status_reg <= ST_STACK;
                                else
                                    state_reg <= S_ROW;
                            end
                            K_REMOVE:
                            begin
                                if (!in_range || !member_reg[vertex])
                                    status_reg <= ST_NOT_MEMBER;
                                else if (level_reg == '0 ||
                                         level_reg > LEVEL_W'(STACK_DEPTH))
                                    status_reg <= ST_STACK;
                                else
                                    state_reg <= S_WALK;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_ROW:
                begin
                    row_reg   <= row_rdata;
                    state_reg <= S_WALK;
                end
                S_WALK:
                begin
                    // Issue stage: read the next vertex's entries.
                    if (rd_idx_reg < VCNT_W'(VERTEX_COUNT))
                    begin
                        rd_idx_reg  <= rd_idx_reg + 1'b1;
                        p_valid_reg <= 1'b1;
                        p_idx_reg   <= rd_idx_reg[VIDX_W-1:0];
                        p_cval_reg  <= crit_vld_reg[rd_idx_reg[VIDX_W-1:0]];
                    end
                    else
                    begin
                        p_valid_reg <= 1'b0;
                    end
                    // Work stage on the data just read.
                    if (p_valid_reg)
                    begin
                        if (kind_reg == K_CHECK && member_reg[p_idx_reg] &&
                            (crit_cur & ~test_mask) == '0)
                        begin
                            viol_reg <= 1'b1;
                        end
                        if (kind_reg == K_REMOVE && p_idx_reg == vtx_reg)
                        begin
                            uncov_reg              <= uncov_reg | crit_cur;
                            crit_vld_reg[vtx_reg]  <= 1'b0;
                        end
                        if (p_idx_reg == VIDX_W'(VERTEX_COUNT - 1))
                        begin
                            state_reg <= S_APPLY;
                        end
                    end
                end
                S_APPLY:
                begin
                    if (kind_reg == K_ADD)
                    begin
                        uncov_reg           <= uncov_reg & ~row_reg;
                        member_reg[vtx_reg] <= 1'b1;
                        level_reg           <= level_reg + 1'b1;
                    end
                    else if (kind_reg == K_REMOVE)
                    begin
                        member_reg[vtx_reg] <= 1'b0;
                        level_reg           <= level_reg - 1'b1;
                    end
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_viol_reg   <= viol_reg;
                        out_uncov_reg  <= uncov_reg;
                        out_status_reg <= status_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: rtl/core/hset_checker.sv
// ============================================================================
// Hitting-set engine port checker
// Watches the top-level ports over time; bound to the top level below.
// ============================================================================
module hset_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_stall,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic                              violates,
    input logic [hset_pkg::EDGE_COUNT-1:0]   uncovered_edges,
    input logic [hset_pkg::STAT_W-1:0]       status
);

    import hset_pkg::*;

    // A result that is held back stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // A result that is held back keeps its fields.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(violates) && $stable(uncovered_edges) &&
        $stable(status))
        else $error("result changed while stalled");

    // The engine works on one item at a time.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second item taken while busy");

    // A violation is only reported by a successful check.
    a_viol_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && violates |-> status == ST_OK)
        else $error("violation with non-ok status");

    // A new result appears only after an item was taken.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without a busy engine");

endmodule

bind hitting_set_crit_table_engine hset_checker u_hset_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .violates        (violates),
    .uncovered_edges (uncovered_edges),
    .status          (status)
);
